// File: rtl/sssag_pkg.sv
// shared types and constants for the sound slot sample address generator
// used by the top level and by its port checker; depends on nothing

package sssag_pkg;

    localparam int ADDR_W     = 20;
    localparam int LOOP_IDX_W = 16;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_BIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_NUMBER   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LINK     = 3'd7;

    // loop modes
    localparam logic [1:0] LOOP_OFF     = 2'd0;
    localparam logic [1:0] LOOP_NORMAL  = 2'd1;
    localparam logic [1:0] LOOP_REVERSE = 2'd2;
    localparam logic [1:0] LOOP_ALT     = 2'd3;

    // envelope phases
    localparam logic [1:0] ENV_ATTACK  = 2'd0;
    localparam logic [1:0] ENV_DECAY1  = 2'd1;
    localparam logic [1:0] ENV_DECAY2  = 2'd2;
    localparam logic [1:0] ENV_RELEASE = 2'd3;

    // request kinds carried on tuser
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_KEY  = 1'b1;

    // result item, lowest field in the lowest bits
    typedef struct packed {
        logic              key_bit;
        logic [1:0]        envelope_phase;
        logic              playing_backward;
        logic              voice_active;
        logic              key_accepted;
        logic [CNT_W-1:0]  sample_index;
        logic [ADDR_W-1:0] address;
    } out_item_t;

    localparam int OUT_ITEM_W = $bits(out_item_t);

endpackage

// File: rtl/sound_slot_sample_address_generator.sv
// top level: voice playback pointer with loop modes, key events and address forming
// one shared 33-bit add/subtract unit driven by a small sequencer
// depends on sssag_pkg
//
// states: a key event goes from accept to DONE; a tick runs INC, PITCH, STEP, CMPA,
//   CMPB, ADDR1, ADDR2 and DONE, adding LEN when an empty or inverted loop clamps, REV1
//   and REV2 for the reverse mirror, or LEN, PREP, DIV, FIN1, FIN2 (upward) for a fold;
//   DIV forms the loop-length remainder one dividend bit per cycle; a waiting result holds DONE
// throughput: one item at a time; s_axis_tready is high only in the idle state, the
//   result register lets the next item start while a result still waits
// reset: rst_n asynchronous, active low; control and voice state to zero, envelope phase to release

module sound_slot_sample_address_generator #(
    parameter int PHASE_FRACTION_BITS = 18
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] key_on, [16:1] pitch_offset, [32:17] sample_modulation, [39:33] zero
    input  logic [sssag_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] req_type
    input  logic                              s_axis_tuser,
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [19:0] address, [51:20] sample_index, [52] key_accepted, [53] voice_active,
    // [54] playing_backward, [56:55] envelope_phase, [57] key_bit, [63:58] zero
    output logic [sssag_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sssag_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sssag_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W  = sssag_pkg::CNT_W;
    localparam int ADDR_W = sssag_pkg::ADDR_W;
    localparam int LW     = sssag_pkg::LOOP_IDX_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INC   = 4'd1;
    localparam logic [3:0] ST_PITCH = 4'd2;
    localparam logic [3:0] ST_STEP  = 4'd3;
    localparam logic [3:0] ST_CMPA  = 4'd4;
    localparam logic [3:0] ST_CMPB  = 4'd5;
    localparam logic [3:0] ST_LEN   = 4'd6;
    localparam logic [3:0] ST_PREP  = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_FIN1  = 4'd9;
    localparam logic [3:0] ST_FIN2  = 4'd10;
    localparam logic [3:0] ST_REV1  = 4'd11;
    localparam logic [3:0] ST_REV2  = 4'd12;
    localparam logic [3:0] ST_ADDR1 = 4'd13;
    localparam logic [3:0] ST_ADDR2 = 4'd14;
    localparam logic [3:0] ST_DONE  = 4'd15;

    localparam int DIV_CNT_W = $clog2(CNT_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(CNT_W - 1);

    // configuration registers
    logic [ADDR_W-1:0] start_address_reg;
    logic [LW-1:0]     loop_start_reg;
    logic [LW-1:0]     loop_end_reg;
    logic              eight_bit_reg;
    logic [1:0]        loop_mode_reg;
    logic [3:0]        octave_reg;
    logic [9:0]        freq_number_reg;
    logic              loop_link_reg;

    // voice state
    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              back_reg, back_next;
    logic              passed_reg, passed_next;
    logic              active_reg, active_next;
    logic [1:0]        env_reg, env_next;
    logic              key_reg, key_next;
    logic              key_acc_reg, key_acc_next;

    // work registers of the sequencer
    logic [15:0]          pitch_reg, pitch_next;
    logic [15:0]          mod_reg, mod_next;
    logic [CNT_W-1:0]     work_reg, work_next;      // dividend, then scratch
    logic [LW-1:0]        rem_reg, rem_next;
    logic [LW-1:0]        len_reg, len_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 fold_down_reg, fold_down_next;
    logic                 ge_ls_reg, ge_ls_next;

    // result register
    sssag_pkg::out_item_t out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    // shared add/subtract unit
    logic [CNT_W-1:0] alu_a, alu_b;
    logic             alu_sub;
    logic [CNT_W:0]   alu_sum;
    logic             alu_cout;

    logic [CNT_W-1:0] ls_ext, le_ext, phase_inc;
    logic [3:0]       shamt;
    logic             in_accept;
    logic             load_out;

    assign ls_ext    = CNT_W'(loop_start_reg);
    assign le_ext    = CNT_W'(loop_end_reg);
    assign shamt     = octave_reg ^ 4'd8;
    // 0x400 | freq, shifted by the octave
    assign phase_inc = CNT_W'({1'b1, freq_number_reg}) << shamt;

    assign alu_sum  = {1'b0, alu_a} + {1'b0, alu_b ^ {CNT_W{alu_sub}}} + (CNT_W+1)'(alu_sub);
    // on a subtract, carry out means a >= b
    assign alu_cout = alu_sum[CNT_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = sssag_pkg::M_TDATA_W'(out_reg);

    // operand selection for the shared unit
    always_comb
    begin
        alu_a   = cnt_reg;
        alu_b   = ls_ext;
        alu_sub = 1'b1;
        case (state_reg)
            ST_INC:
            begin
                alu_a   = CNT_W'(phase_reg[PHASE_FRACTION_BITS-1:0]);
                alu_b   = phase_inc;
                alu_sub = 1'b0;
            end
            ST_PITCH:
            begin
                alu_a   = phase_reg;
                alu_b   = {{(CNT_W-16){pitch_reg[15]}}, pitch_reg};
                alu_sub = 1'b0;
            end
            ST_STEP:
            begin
                // whole part of the phase moves the counter
                alu_a   = cnt_reg;
                alu_b   = CNT_W'(phase_reg[CNT_W-1:PHASE_FRACTION_BITS]);
                alu_sub = back_reg;
            end
            ST_CMPA:
            begin
                alu_a = cnt_reg;
                alu_b = ls_ext;
            end
            ST_CMPB:
            begin
                // reverse and alternate going backward look for counter <= loop start
                if (back_reg && loop_mode_reg[1])
                begin
                    alu_a = ls_ext;
                    alu_b = cnt_reg;
                end
                else
                begin
                    alu_a = cnt_reg;
                    alu_b = le_ext;
                end
            end
            ST_LEN:
            begin
                alu_a = le_ext;
                alu_b = ls_ext;
            end
            ST_PREP:
            begin
                if (fold_down_reg)
                begin
                    alu_a = cnt_reg;
                    alu_b = ls_ext;
                end
                else
                begin
                    alu_a = ls_ext;
                    alu_b = cnt_reg;
                end
            end
            ST_DIV:
            begin
                alu_a = CNT_W'({rem_reg, work_reg[CNT_W-1]});
                alu_b = CNT_W'(len_reg);
            end
            ST_FIN1:
            begin
                if (fold_down_reg)
                begin
                    alu_a   = ls_ext;
                    alu_b   = CNT_W'(rem_reg);
                    alu_sub = 1'b0;
                end
                else
                begin
                    alu_a = CNT_W'(len_reg);
                    alu_b = CNT_W'(rem_reg);
                end
            end
            ST_FIN2:
            begin
                alu_a   = ls_ext;
                alu_b   = work_reg;
                alu_sub = 1'b0;
            end
            ST_REV1:
            begin
                alu_a = le_ext;
                alu_b = cnt_reg;
            end
            ST_REV2:
            begin
                alu_a   = work_reg;
                alu_b   = ls_ext;
                alu_sub = 1'b0;
            end
            ST_ADDR1:
            begin
                alu_a   = cnt_reg;
                alu_b   = {{(CNT_W-16){mod_reg[15]}}, mod_reg};
                alu_sub = 1'b0;
            end
            ST_ADDR2:
            begin
                // 16-bit samples take two bytes per index
                alu_a   = CNT_W'(start_address_reg);
                alu_b   = eight_bit_reg ? work_reg : {work_reg[CNT_W-2:0], 1'b0};
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a   = cnt_reg;
                alu_b   = ls_ext;
                alu_sub = 1'b1;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        back_next      = back_reg;
        passed_next    = passed_reg;
        active_next    = active_reg;
        env_next       = env_reg;
        key_next       = key_reg;
        key_acc_next   = key_acc_reg;
        pitch_next     = pitch_reg;
        mod_next       = mod_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        len_next       = len_reg;
        div_cnt_next   = div_cnt_reg;
        fold_down_next = fold_down_reg;
        ge_ls_next     = ge_ls_reg;
        load_out       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    pitch_next = s_axis_tdata[16:1];
                    mod_next   = s_axis_tdata[32:17];
                    if (s_axis_tuser == sssag_pkg::REQ_KEY)
                    begin
                        // key on is taken only in release, key off only outside it
                        key_next     = s_axis_tdata[0];
                        key_acc_next = ((env_reg == sssag_pkg::ENV_RELEASE) == s_axis_tdata[0]);
                        if ((env_reg == sssag_pkg::ENV_RELEASE) == s_axis_tdata[0])
                        begin
                            if (s_axis_tdata[0])
                            begin
                                active_next = 1'b1;
                                env_next    = sssag_pkg::ENV_ATTACK;
                                phase_next  = '0;
                                cnt_next    = '0;
                                addr_next   = '0;
                                back_next   = 1'b0;
                                passed_next = 1'b0;
                            end
                            else
                            begin
                                env_next = sssag_pkg::ENV_RELEASE;
                            end
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        key_acc_next = 1'b0;
                        state_next   = ST_INC;
                    end
                end
            end
            ST_INC:
            begin
                phase_next = alu_sum[CNT_W-1:0];
                state_next = ST_PITCH;
            end
            ST_PITCH:
            begin
                phase_next = alu_sum[CNT_W-1:0];
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                cnt_next   = alu_sum[CNT_W-1:0];
                state_next = ST_CMPA;
            end
            ST_CMPA:
            begin
                ge_ls_next = alu_cout;
                // first forward crossing of the loop start
                if (!back_reg && !passed_reg && alu_cout)
                begin
                    passed_next = 1'b1;
                    if (loop_link_reg && env_reg == sssag_pkg::ENV_ATTACK)
                    begin
                        env_next = sssag_pkg::ENV_DECAY1;
                    end
                end
                state_next = ST_CMPB;
            end
            ST_CMPB:
            begin
                state_next = ST_ADDR1;
                case (loop_mode_reg)
                    sssag_pkg::LOOP_OFF:
                    begin
                        // end of a one-shot sample
                        if (alu_cout)
                        begin
                            active_next = 1'b0;
                            key_next    = 1'b0;
                        end
                    end
                    sssag_pkg::LOOP_NORMAL:
                    begin
                        if (alu_cout)
                        begin
                            fold_down_next = 1'b1;
                            state_next     = ST_LEN;
                        end
                    end
                    sssag_pkg::LOOP_REVERSE:
                    begin
                        if (back_reg)
                        begin
                            if (alu_cout)
                            begin
                                fold_down_next = 1'b0;
                                state_next     = ST_LEN;
                            end
                        end
                        else if (ge_ls_reg)
                        begin
                            // mirror into the loop and turn around
                            back_next  = 1'b1;
                            state_next = ST_REV1;
                        end
                    end
                    default:
                    begin
                        if (alu_cout)
                        begin
                            back_next      = !back_reg;
                            fold_down_next = !back_reg;
                            state_next     = ST_LEN;
                        end
                    end
                endcase
            end
            ST_LEN:
            begin
                // empty or inverted loop clamps to the loop start
                if (!alu_cout || alu_sum[LW-1:0] == '0)
                begin
                    cnt_next   = ls_ext;
                    state_next = ST_ADDR1;
                end
                else
                begin
                    len_next   = alu_sum[LW-1:0];
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                work_next    = alu_sum[CNT_W-1:0];
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring remainder, one dividend bit per cycle
                if (alu_cout)
                begin
                    rem_next = alu_sum[LW-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[LW-2:0], work_reg[CNT_W-1]};
                end
                work_next    = {work_reg[CNT_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FIN1;
                end
            end
            ST_FIN1:
            begin
                if (fold_down_reg)
                begin
                    cnt_next   = alu_sum[CNT_W-1:0];
                    state_next = ST_ADDR1;
                end
                else
                begin
                    work_next  = alu_sum[CNT_W-1:0];
                    state_next = ST_FIN2;
                end
            end
            ST_FIN2:
            begin
                cnt_next   = alu_sum[CNT_W-1:0];
                state_next = ST_ADDR1;
            end
            ST_REV1:
            begin
                work_next  = alu_sum[CNT_W-1:0];
                state_next = ST_REV2;
            end
            ST_REV2:
            begin
                cnt_next   = alu_sum[CNT_W-1:0];
                state_next = ST_ADDR1;
            end
            ST_ADDR1:
            begin
                work_next  = alu_sum[CNT_W-1:0];
                state_next = ST_ADDR2;
            end
            ST_ADDR2:
            begin
                addr_next  = alu_sum[ADDR_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hand over once the result register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next            = 1'b1;
            out_next.address          = addr_reg;
            out_next.sample_index     = cnt_reg;
            out_next.key_accepted     = key_acc_reg;
            out_next.voice_active     = active_reg;
            out_next.playing_backward = back_reg;
            out_next.envelope_phase   = env_reg;
            out_next.key_bit          = key_reg;
        end
    end

    // control and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            phase_reg         <= '0;
            cnt_reg           <= '0;
            addr_reg          <= '0;
            back_reg          <= 1'b0;
            passed_reg        <= 1'b0;
            active_reg        <= 1'b0;
            env_reg           <= sssag_pkg::ENV_RELEASE;
            key_reg           <= 1'b0;
            key_acc_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            start_address_reg <= '0;
            loop_start_reg    <= '0;
            loop_end_reg      <= '0;
            eight_bit_reg     <= 1'b0;
            loop_mode_reg     <= sssag_pkg::LOOP_OFF;
            octave_reg        <= '0;
            freq_number_reg   <= '0;
            loop_link_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            addr_reg      <= addr_next;
            back_reg      <= back_next;
            passed_reg    <= passed_next;
            active_reg    <= active_next;
            env_reg       <= env_next;
            key_reg       <= key_next;
            key_acc_reg   <= key_acc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sssag_pkg::CFG_START_ADDRESS: start_address_reg <= cfg_data[ADDR_W-1:0];
                    sssag_pkg::CFG_LOOP_START:    loop_start_reg    <= cfg_data[LW-1:0];
                    sssag_pkg::CFG_LOOP_END:      loop_end_reg      <= cfg_data[LW-1:0];
                    sssag_pkg::CFG_EIGHT_BIT:     eight_bit_reg     <= cfg_data[0];
                    sssag_pkg::CFG_LOOP_MODE:     loop_mode_reg     <= cfg_data[1:0];
                    sssag_pkg::CFG_OCTAVE:        octave_reg        <= cfg_data[3:0];
                    sssag_pkg::CFG_FREQ_NUMBER:   freq_number_reg   <= cfg_data[9:0];
                    sssag_pkg::CFG_LOOP_LINK:     loop_link_reg     <= cfg_data[0];
                    default:                      loop_link_reg     <= loop_link_reg;
                endcase
            end
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        pitch_reg     <= pitch_next;
        mod_reg       <= mod_next;
        work_reg      <= work_next;
        rem_reg       <= rem_next;
        len_reg       <= len_next;
        div_cnt_reg   <= div_cnt_next;
        fold_down_reg <= fold_down_next;
        ge_ls_reg     <= ge_ls_next;
        out_reg       <= out_next;
    end

endmodule

// File: rtl/sssag_checker.sv
// port-level checker for the sound slot sample address generator, with its bind
// depends on sssag_pkg

module sssag_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [sssag_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    sssag_pkg::out_item_t item;

    assign item = m_axis_tdata[sssag_pkg::OUT_ITEM_W-1:0];

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // accepted key on restarts the pointer
    a_key_on_restart: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && item.key_accepted && item.key_bit
        |-> item.sample_index == '0 && item.address == '0 && item.voice_active
            && !item.playing_backward && item.envelope_phase == sssag_pkg::ENV_ATTACK)
        else $error("accepted key on did not restart the voice");

    // accepted key off enters release
    a_key_off_release: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && item.key_accepted && !item.key_bit
        |-> item.envelope_phase == sssag_pkg::ENV_RELEASE)
        else $error("accepted key off did not enter release");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[sssag_pkg::M_TDATA_W-1:sssag_pkg::OUT_ITEM_W] == '0)
        else $error("result padding not zero");

endmodule

bind sound_slot_sample_address_generator sssag_checker u_sssag_checker (.*);
